[design/mm_pkg.sv]
package mm_pkg;

   localparam int DEF_MAX_DIM   = 8;
   localparam int DEF_FRAC_BITS = 16;

   localparam int ELEM_W  = 32;
   localparam int DIM_W   = 4;
   localparam int INDEX_W = 3;

   localparam logic [DIM_W-1:0] DIM_RESET = 4'd8;

   // request codes
   localparam logic [1:0] REQ_LOAD_A = 2'd0;
   localparam logic [1:0] REQ_LOAD_B = 2'd1;
   localparam logic [1:0] REQ_START  = 2'd2;

   // configuration register indexes
   localparam logic [1:0] CSR_ROWS_A    = 2'd0;
   localparam logic [1:0] CSR_INNER_DIM = 2'd1;
   localparam logic [1:0] CSR_COLS_B    = 2'd2;

   // sequencer to multiply-accumulate unit
   typedef struct packed {
      logic valid;  // operands read this cycle
      logic fin;    // last term of the current element
      logic clear;  // zero the accumulator
   } mm_ctl_type;

endpackage

[design/mm_ram.sv]
module mm_ram
   import mm_pkg::*;
#(
   parameter int DEPTH = DEF_MAX_DIM * DEF_MAX_DIM,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [AW-1:0]     wr_addr,
   input  logic [ELEM_W-1:0] wr_data,
   input  logic [AW-1:0]     rd_addr,
   output logic [ELEM_W-1:0] rd_data
);

   logic [ELEM_W-1:0] mem_ff [DEPTH];
   logic [ELEM_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[design/mm_mac.sv]
module mm_mac
   import mm_pkg::*;
#(
   parameter int MAX_DIM   = DEF_MAX_DIM,
   parameter int FRAC_BITS = DEF_FRAC_BITS
) (
   input  logic              clock,
   input  logic              reset,
   input  mm_ctl_type        ctl,
   input  logic [ELEM_W-1:0] a_data,
   input  logic [ELEM_W-1:0] b_data,
   output logic              done,
   output logic [ELEM_W-1:0] value,
   output logic              saturated
);

   // room for the exact sum of MAX_DIM full products
   localparam int ACC_W = 2 * ELEM_W + ((MAX_DIM > 1) ? $clog2(MAX_DIM) : 0) + 1;

   logic                        v1_ff, f1_ff, v2_ff, f2_ff, f3_ff;
   logic signed [2*ELEM_W-1:0]  prod_ff;
   logic signed [ACC_W-1:0]     acc_ff, acc_in;
   logic signed [ACC_W-1:0]     shifted;
   logic [ACC_W-1:ELEM_W-1]     top_bits;
   logic                        fits;

   // stage 1 tags travel with the registered RAM read data
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         f1_ff <= 1'b0;
         v2_ff <= 1'b0;
         f2_ff <= 1'b0;
         f3_ff <= 1'b0;
      end else begin
         v1_ff <= ctl.valid;
         f1_ff <= ctl.fin;
         v2_ff <= v1_ff;
         f2_ff <= f1_ff;
         f3_ff <= f2_ff;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= $signed(a_data) * $signed(b_data);
      acc_ff  <= acc_in;
   end

   always_comb begin
      acc_in = acc_ff;
      if (ctl.clear) begin
         acc_in = '0;
      end else if (v2_ff) begin
         acc_in = acc_ff + ACC_W'(prod_ff);
      end
   end

   assign shifted  = acc_ff >>> FRAC_BITS;
   assign top_bits = shifted[ACC_W-1:ELEM_W-1];
   assign fits     = (&top_bits) || !(|top_bits);

   always_comb begin
      if (fits) begin
         value = shifted[ELEM_W-1:0];
      end else if (shifted[ACC_W-1]) begin
         value = {1'b1, {(ELEM_W-1){1'b0}}};
      end else begin
         value = {1'b0, {(ELEM_W-1){1'b1}}};
      end
   end

   assign saturated = !fits;
   assign done      = f3_ff;

endmodule

[design/matrix_multiply.sv]
// Load transactions (left or right element) leave busy low.
// A start transaction produces rows_a x cols_b results (each size clamped to MAX_DIM),
// each computed in turn on the shared multiply-accumulate unit.
// busy is high until the last result is strobed. Results cannot be stalled.
// Synchronous reset sets each dimension register to 8; element stores are not cleared.
module matrix_multiply
   import mm_pkg::*;
#(
   parameter int MAX_DIM   = DEF_MAX_DIM,
   parameter int FRAC_BITS = DEF_FRAC_BITS
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_type,
   input  logic [INDEX_W-1:0] req_row_index,
   input  logic [INDEX_W-1:0] req_col_index,
   input  logic [ELEM_W-1:0]  req_elem_value,
   output logic               rsp_valid,
   output logic [INDEX_W-1:0] rsp_out_row,
   output logic [INDEX_W-1:0] rsp_out_col,
   output logic [ELEM_W-1:0]  rsp_out_value,
   output logic               rsp_last,
   output logic               rsp_saturated,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [DIM_W-1:0]   csr_wdata
);

   localparam int DEPTH = MAX_DIM * MAX_DIM;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int IW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
   localparam int DW    = $clog2(MAX_DIM + 1);

   typedef enum logic [1:0] {S_IDLE, S_ISSUE, S_WAIT} state_type;

   state_type          state_ff, state_in;
   logic [DIM_W-1:0]   rows_a_ff, inner_dim_ff, cols_b_ff;
   logic [DW-1:0]      r_ff, r_in, n_ff, n_in, c_ff, c_in;
   logic [IW-1:0]      i_ff, i_in, j_ff, j_in, k_ff, k_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [INDEX_W-1:0] rsp_row_ff, rsp_row_in, rsp_col_ff, rsp_col_in;
   logic [ELEM_W-1:0]  rsp_value_ff, rsp_value_in;
   logic               rsp_last_ff, rsp_last_in, rsp_sat_ff, rsp_sat_in;

   logic               accept, in_range, k_last, j_last, i_last;
   logic [DW-1:0]      eff_r, eff_n, eff_c;
   logic [AW-1:0]      wr_addr, a_addr, b_addr;
   logic [ELEM_W-1:0]  a_data, b_data, mac_value;
   logic               mac_done, mac_sat;
   mm_ctl_type         ctl;

   function automatic logic [DW-1:0] eff_dim(input logic [DIM_W-1:0] d);
      if (32'(d) > MAX_DIM) begin
         return DW'(MAX_DIM);
      end
      return DW'(d);
   endfunction

   assign busy      = (state_ff != S_IDLE);
   assign accept    = start && !busy;
   assign csr_ready = 1'b1;

   assign eff_r = eff_dim(rows_a_ff);
   assign eff_n = eff_dim(inner_dim_ff);
   assign eff_c = eff_dim(cols_b_ff);

   assign in_range = (32'(req_row_index) < MAX_DIM) && (32'(req_col_index) < MAX_DIM);
   assign wr_addr  = AW'(AW'(req_row_index) * AW'(MAX_DIM) + AW'(req_col_index));
   assign a_addr   = AW'(AW'(i_ff) * AW'(MAX_DIM) + AW'(k_ff));
   assign b_addr   = AW'(AW'(k_ff) * AW'(MAX_DIM) + AW'(j_ff));

   assign k_last = (n_ff == '0) || (DW'(k_ff) + DW'(1) == n_ff);
   assign j_last = (DW'(j_ff) + DW'(1) == c_ff);
   assign i_last = (DW'(i_ff) + DW'(1) == r_ff);

   mm_ram #(.DEPTH(DEPTH), .AW(AW)) u_left (
      .clock   (clock),
      .wr_en   (accept && (req_type == REQ_LOAD_A) && in_range),
      .wr_addr (wr_addr),
      .wr_data (req_elem_value),
      .rd_addr (a_addr),
      .rd_data (a_data)
   );

   mm_ram #(.DEPTH(DEPTH), .AW(AW)) u_right (
      .clock   (clock),
      .wr_en   (accept && (req_type == REQ_LOAD_B) && in_range),
      .wr_addr (wr_addr),
      .wr_data (req_elem_value),
      .rd_addr (b_addr),
      .rd_data (b_data)
   );

   mm_mac #(.MAX_DIM(MAX_DIM), .FRAC_BITS(FRAC_BITS)) u_mac (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .a_data    (a_data),
      .b_data    (b_data),
      .done      (mac_done),
      .value     (mac_value),
      .saturated (mac_sat)
   );

   always_comb begin
      state_in     = state_ff;
      r_in         = r_ff;
      n_in         = n_ff;
      c_in         = c_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      k_in         = k_ff;
      rsp_valid_in = 1'b0;
      rsp_row_in   = rsp_row_ff;
      rsp_col_in   = rsp_col_ff;
      rsp_value_in = rsp_value_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_sat_in   = rsp_sat_ff;
      ctl          = '0;
      case (state_ff)
         S_IDLE: begin
            ctl.clear = 1'b1;
            if (accept && (req_type == REQ_START)) begin
               r_in = eff_r;
               n_in = eff_n;
               c_in = eff_c;
               i_in = '0;
               j_in = '0;
               k_in = '0;
               // empty result: nothing to run
               if ((eff_r != '0) && (eff_c != '0)) begin
                  state_in = S_ISSUE;
               end
            end
         end
         S_ISSUE: begin
            ctl.valid = (n_ff != '0);
            ctl.fin   = k_last;
            if (k_last) begin
               k_in     = '0;
               state_in = S_WAIT;
            end else begin
               k_in = k_ff + IW'(1);
            end
         end
         S_WAIT: begin
            if (mac_done) begin
               ctl.clear    = 1'b1;
               rsp_valid_in = 1'b1;
               rsp_row_in   = INDEX_W'(i_ff);
               rsp_col_in   = INDEX_W'(j_ff);
               rsp_value_in = mac_value;
               rsp_sat_in   = mac_sat;
               rsp_last_in  = i_last && j_last;
               if (i_last && j_last) begin
                  state_in = S_IDLE;
               end else begin
                  state_in = S_ISSUE;
                  if (j_last) begin
                     j_in = '0;
                     i_in = i_ff + IW'(1);
                  end else begin
                     j_in = j_ff + IW'(1);
                  end
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         rows_a_ff    <= DIM_RESET;
         inner_dim_ff <= DIM_RESET;
         cols_b_ff    <= DIM_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_row_ff   <= rsp_row_in;
         rsp_col_ff   <= rsp_col_in;
         rsp_value_ff <= rsp_value_in;
         rsp_last_ff  <= rsp_last_in;
         rsp_sat_ff   <= rsp_sat_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_ROWS_A:    rows_a_ff    <= csr_wdata;
               CSR_INNER_DIM: inner_dim_ff <= csr_wdata;
               CSR_COLS_B:    cols_b_ff    <= csr_wdata;
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      r_ff <= r_in;
      n_ff <= n_in;
      c_ff <= c_in;
      i_ff <= i_in;
      j_ff <= j_in;
      k_ff <= k_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_row   = rsp_row_ff;
   assign rsp_out_col   = rsp_col_ff;
   assign rsp_out_value = rsp_value_ff;
   assign rsp_last      = rsp_last_ff;
   assign rsp_saturated = rsp_sat_ff;

   // a result only follows a cycle of work
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result strobe without a run in progress");

   // results are spaced by the accumulator pipeline
   a_rsp_spaced: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("back-to-back result strobes");

   // the final result of a run releases the block
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last) |-> !busy)
      else $error("still busy after the last result");

   a_last_strobe: assert property (@(posedge clock) disable iff (reset)
      (busy && !rsp_valid) |=> !(rsp_valid && rsp_last && $past(state_ff == S_ISSUE)))
      else $error("last result issued straight from the issue phase");

endmodule

[bench/tb.sv]
`timescale 1ns / 1ps

module tb
   import mm_pkg::*;
();

   localparam int ITEMS      = 310;
   localparam int CALM_TAIL  = 40;
   localparam int SETTLE     = 16;
   localparam int END_WAIT   = 40;
   localparam int STALL_MAX  = 2000;
   localparam int DIR_ROWS   = 23;

   localparam logic [1:0] REQ_UNUSED = 2'd3;
   localparam logic [1:0] CSR_UNUSED = 2'd3;

   typedef struct packed {
      logic [INDEX_W-1:0] out_row;
      logic [INDEX_W-1:0] out_col;
      logic [ELEM_W-1:0]  out_value;
      logic               last;
      logic               sat;
   } elem_type;

   typedef struct packed {
      logic [1:0]         op;
      logic [INDEX_W-1:0] row;
      logic [INDEX_W-1:0] col;
      logic [ELEM_W-1:0]  data;
      logic               typed;
      logic [ELEM_W-1:0]  want;
      logic               want_sat;
   } dir_row_type;

   logic               clock;
   logic               reset          = 1'b1;
   logic               start          = 1'b0;
   logic               busy;
   logic [1:0]         req_type       = REQ_LOAD_A;
   logic [INDEX_W-1:0] req_row_index  = '0;
   logic [INDEX_W-1:0] req_col_index  = '0;
   logic [ELEM_W-1:0]  req_elem_value = '0;
   logic               rsp_valid;
   logic [INDEX_W-1:0] rsp_out_row;
   logic [INDEX_W-1:0] rsp_out_col;
   logic [ELEM_W-1:0]  rsp_out_value;
   logic               rsp_last;
   logic               rsp_saturated;
   logic               csr_valid      = 1'b0;
   logic               csr_ready;
   logic [1:0]         csr_index      = CSR_ROWS_A;
   logic [DIM_W-1:0]   csr_wdata      = '0;

   // shadow copy of the block's state
   logic signed [ELEM_W-1:0] left_mat  [DEF_MAX_DIM][DEF_MAX_DIM];
   logic signed [ELEM_W-1:0] right_mat [DEF_MAX_DIM][DEF_MAX_DIM];
   bit                       left_set  [DEF_MAX_DIM][DEF_MAX_DIM];
   bit                       right_set [DEF_MAX_DIM][DEF_MAX_DIM];
   logic [DIM_W-1:0]         dim_rows  = DIM_RESET;
   logic [DIM_W-1:0]         dim_inner = DIM_RESET;
   logic [DIM_W-1:0]         dim_cols  = DIM_RESET;

   elem_type    product_q [$];
   elem_type    head;
   dir_row_type dir_tab [DIR_ROWS];

   int  mismatches   = 0;
   int  results_seen = 0;
   int  items_sent   = 0;
   int  starts_sent  = 0;
   int  csr_writes   = 0;
   int  stall_cycles = 0;
   bit  calm         = 1'b0;

   matrix_multiply uut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_type       (req_type),
      .req_row_index  (req_row_index),
      .req_col_index  (req_col_index),
      .req_elem_value (req_elem_value),
      .rsp_valid      (rsp_valid),
      .rsp_out_row    (rsp_out_row),
      .rsp_out_col    (rsp_out_col),
      .rsp_out_value  (rsp_out_value),
      .rsp_last       (rsp_last),
      .rsp_saturated  (rsp_saturated),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic int clamp_dim(logic [DIM_W-1:0] d);
      return (d > DEF_MAX_DIM) ? DEF_MAX_DIM : int'(d);
   endfunction

   // append one expected result element to the tail of the queue
   task automatic add_expected(elem_type e);
      product_q = {product_q, e};
   endtask

   // exact sum of products, arithmetic shift, clip to 32 bits
   function automatic logic [ELEM_W-1:0] dot_value(int i, int j, int n, output logic sat);
      logic signed [127:0] acc;
      logic signed [127:0] shifted;
      longint              prod;
      acc = '0;
      for (int k = 0; k < n; k++) begin
         prod = longint'(left_mat[i][k]) * longint'(right_mat[k][j]);
         acc  = acc + prod;
      end
      shifted = acc >>> DEF_FRAC_BITS;
      sat = 1'b1;
      if (shifted > 128'sd2147483647) return 32'h7FFF_FFFF;
      if (shifted < -128'sd2147483648) return 32'h8000_0000;
      sat = 1'b0;
      return shifted[ELEM_W-1:0];
   endfunction

   task automatic predict_product();
      int       r;
      int       n;
      int       c;
      elem_type e;
      logic     s;
      r = clamp_dim(dim_rows);
      n = clamp_dim(dim_inner);
      c = clamp_dim(dim_cols);
      for (int i = 0; i < r; i++) begin
         for (int j = 0; j < c; j++) begin
            e.out_row   = INDEX_W'(i);
            e.out_col   = INDEX_W'(j);
            e.out_value = dot_value(i, j, n, s);
            e.sat       = s;
            e.last      = (i == r - 1) && (j == c - 1);
            add_expected(e);
         end
      end
   endtask

   function automatic logic [ELEM_W-1:0] rand_elem();
      logic [ELEM_W-1:0] mag;
      case ($urandom_range(0, 19))
         0:  return 32'h7FFF_FFFF;
         1:  return 32'h8000_0000;
         2:  return 32'h0000_0000;
         3:  return 32'hFFFF_FFFF;
         4, 5, 6, 7, 8, 9, 10: return $urandom;
         default: begin
            // keep within +/-4.0 so sums mostly stay in range
            mag = $urandom_range(0, 32'h0004_0000);
            return $urandom_range(0, 1) ? -mag : mag;
         end
      endcase
   endfunction

   function automatic logic [INDEX_W-1:0] pick_index(logic [DIM_W-1:0] d);
      int e;
      e = clamp_dim(d);
      if (e == 0 || $urandom_range(0, 4) == 0) return INDEX_W'($urandom_range(0, 7));
      return INDEX_W'($urandom_range(0, e - 1));
   endfunction

   function automatic int pick_gap();
      if (calm || items_sent >= ITEMS - CALM_TAIL) return 0;
      if ($urandom_range(0, 3) == 0) return $urandom_range(1, 14);
      return 0;
   endfunction

   function automatic dir_row_type drow(logic [1:0] op, int r, int c, logic [ELEM_W-1:0] d,
                                        bit typed, logic [ELEM_W-1:0] want, bit sat);
      dir_row_type t;
      t.op       = op;
      t.row      = INDEX_W'(r);
      t.col      = INDEX_W'(c);
      t.data     = d;
      t.typed    = typed;
      t.want     = want;
      t.want_sat = sat;
      return t;
   endfunction

   task automatic note_mismatch(string what, logic [ELEM_W-1:0] got, logic [ELEM_W-1:0] want);
      mismatches++;
      $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
   endtask

   // present one transaction; hold start high afterwards unless a gap follows
   task automatic send_item(logic [1:0] op, logic [INDEX_W-1:0] r, logic [INDEX_W-1:0] c,
                            logic [ELEM_W-1:0] d, int gap, bit predict);
      start          <= 1'b1;
      req_type       <= op;
      req_row_index  <= r;
      req_col_index  <= c;
      req_elem_value <= d;
      @(posedge clock);
      while (busy) @(posedge clock);
      items_sent++;
      case (op)
         REQ_LOAD_A: begin
            left_mat[r][c] = d;
            left_set[r][c] = 1'b1;
         end
         REQ_LOAD_B: begin
            right_mat[r][c] = d;
            right_set[r][c] = 1'b1;
         end
         REQ_START: begin
            starts_sent++;
            if (predict) predict_product();
         end
         default: ;
      endcase
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_drain();
      if (start) start <= 1'b0;
      while (product_q.size() != 0 || busy) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic csr_put(logic [1:0] idx, logic [DIM_W-1:0] d);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= d;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_writes++;
      case (idx)
         CSR_ROWS_A:    dim_rows  = d;
         CSR_INNER_DIM: dim_inner = d;
         CSR_COLS_B:    dim_cols  = d;
         default: ;
      endcase
   endtask

   task automatic write_dims(logic [DIM_W-1:0] r, logic [DIM_W-1:0] n, logic [DIM_W-1:0] c,
                             bit poke_unused);
      wait_drain();
      csr_put(CSR_ROWS_A, r);
      csr_put(CSR_INNER_DIM, n);
      csr_put(CSR_COLS_B, c);
      if (poke_unused) csr_put(CSR_UNUSED, DIM_W'($urandom));
      csr_valid <= 1'b0;
   endtask

   // load every element the next start will read that was never written
   task automatic fill_missing();
      int r;
      int n;
      int c;
      r = clamp_dim(dim_rows);
      n = clamp_dim(dim_inner);
      c = clamp_dim(dim_cols);
      if (r == 0 || c == 0) return;
      for (int i = 0; i < r; i++) begin
         for (int k = 0; k < n; k++) begin
            if (!left_set[i][k]) begin
               send_item(REQ_LOAD_A, INDEX_W'(i), INDEX_W'(k), rand_elem(), pick_gap(), 1'b1);
            end
         end
      end
      for (int k = 0; k < n; k++) begin
         for (int j = 0; j < c; j++) begin
            if (!right_set[k][j]) begin
               send_item(REQ_LOAD_B, INDEX_W'(k), INDEX_W'(j), rand_elem(), pick_gap(), 1'b1);
            end
         end
      end
   endtask

   task automatic run_phase(logic [DIM_W-1:0] r, logic [DIM_W-1:0] n, logic [DIM_W-1:0] c,
                            bit poke_unused);
      int                 rounds;
      int                 loads;
      logic [INDEX_W-1:0] ri;
      logic [INDEX_W-1:0] ci;
      write_dims(r, n, c, poke_unused);
      calm   = ($urandom_range(0, 2) == 0);
      rounds = $urandom_range(1, 3);
      for (int rd = 0; rd < rounds; rd++) begin
         loads = $urandom_range(0, 8);
         for (int l = 0; l < loads; l++) begin
            if ($urandom_range(0, 9) == 0) begin
               // unused request code, ignored by the block
               send_item(REQ_UNUSED, INDEX_W'($urandom), INDEX_W'($urandom), $urandom,
                         pick_gap(), 1'b1);
            end else if ($urandom_range(0, 1) == 0) begin
               ri = pick_index(dim_rows);
               ci = pick_index(dim_inner);
               send_item(REQ_LOAD_A, ri, ci, rand_elem(), pick_gap(), 1'b1);
            end else begin
               ri = pick_index(dim_inner);
               ci = pick_index(dim_cols);
               send_item(REQ_LOAD_B, ri, ci, rand_elem(), pick_gap(), 1'b1);
            end
         end
         fill_missing();
         send_item(REQ_START, INDEX_W'($urandom), INDEX_W'($urandom), $urandom,
                   pick_gap(), 1'b1);
         if ($urandom_range(0, 4) == 0) wait_drain();
      end
   endtask

   function automatic logic [DIM_W-1:0] rand_dim();
      if ($urandom_range(0, 9) == 0) return DIM_W'($urandom_range(0, 15));
      return DIM_W'($urandom_range(1, 4));
   endfunction

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (product_q.size() == 0) begin
            note_mismatch("result with nothing expected", rsp_out_value, '0);
         end else begin
            head = product_q.pop_front();
            results_seen++;
            if (rsp_out_row !== head.out_row)
               note_mismatch("out_row", ELEM_W'(rsp_out_row), ELEM_W'(head.out_row));
            if (rsp_out_col !== head.out_col)
               note_mismatch("out_col", ELEM_W'(rsp_out_col), ELEM_W'(head.out_col));
            if (rsp_out_value !== head.out_value)
               note_mismatch("out_value", rsp_out_value, head.out_value);
            if (rsp_last !== head.last)
               note_mismatch("last", ELEM_W'(rsp_last), ELEM_W'(head.last));
            if (rsp_saturated !== head.sat)
               note_mismatch("saturated", ELEM_W'(rsp_saturated), ELEM_W'(head.sat));
         end
      end
   end

   initial begin
      while (stall_cycles < STALL_MAX) @(posedge clock);
      $display("watchdog: no transaction for %0d cycles, %0d results pending",
               STALL_MAX, product_q.size());
      $display("TEST FAILED");
      $finish;
   end

   initial begin
      elem_type e;
      // 1x1x1 rows; typed expectations are read straight off the arithmetic
      dir_tab[0]  = drow(REQ_LOAD_A, 0, 0, 32'h0001_0000, 0, '0, 0);
      dir_tab[1]  = drow(REQ_LOAD_B, 0, 0, 32'h0002_0000, 0, '0, 0);
      dir_tab[2]  = drow(REQ_START,  0, 0, '0,            1, 32'h0002_0000, 0);
      dir_tab[3]  = drow(REQ_LOAD_A, 0, 0, 32'h7FFF_FFFF, 0, '0, 0);
      dir_tab[4]  = drow(REQ_LOAD_B, 0, 0, 32'h0001_0000, 0, '0, 0);
      dir_tab[5]  = drow(REQ_START,  0, 0, '0,            1, 32'h7FFF_FFFF, 0);
      dir_tab[6]  = drow(REQ_LOAD_B, 0, 0, 32'h7FFF_FFFF, 0, '0, 0);
      dir_tab[7]  = drow(REQ_START,  0, 0, '0,            1, 32'h7FFF_FFFF, 1);
      dir_tab[8]  = drow(REQ_LOAD_B, 0, 0, 32'h8000_0000, 0, '0, 0);
      dir_tab[9]  = drow(REQ_START,  0, 0, '0,            1, 32'h8000_0000, 1);
      dir_tab[10] = drow(REQ_LOAD_A, 0, 0, 32'h8000_0000, 0, '0, 0);
      dir_tab[11] = drow(REQ_START,  0, 0, '0,            1, 32'h7FFF_FFFF, 1);
      dir_tab[12] = drow(REQ_LOAD_B, 0, 0, 32'h0001_0000, 0, '0, 0);
      dir_tab[13] = drow(REQ_START,  0, 0, '0,            1, 32'h8000_0000, 0);
      dir_tab[14] = drow(REQ_LOAD_A, 0, 0, 32'hFFFF_FFFF, 0, '0, 0);
      dir_tab[15] = drow(REQ_START,  0, 0, '0,            1, 32'hFFFF_FFFF, 0);
      dir_tab[16] = drow(REQ_LOAD_B, 0, 0, 32'h0000_0001, 0, '0, 0);
      dir_tab[17] = drow(REQ_START,  7, 7, 32'hFFFF_FFFF, 0, '0, 0);
      dir_tab[18] = drow(REQ_UNUSED, 7, 7, 32'hFFFF_FFFF, 0, '0, 0);
      dir_tab[19] = drow(REQ_LOAD_A, 7, 7, 32'h1234_5678, 0, '0, 0);
      dir_tab[20] = drow(REQ_LOAD_B, 7, 7, 32'hFFFF_FFFF, 0, '0, 0);
      dir_tab[21] = drow(REQ_LOAD_A, 0, 0, 32'h0000_0000, 0, '0, 0);
      dir_tab[22] = drow(REQ_START,  0, 0, '0,            1, 32'h0000_0000, 0);

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // rows and columns stay at their reset size for the first product
      csr_put(CSR_INNER_DIM, 4'd1);
      csr_valid <= 1'b0;
      fill_missing();
      send_item(REQ_START, '0, '0, '0, pick_gap(), 1'b1);

      write_dims(4'd1, 4'd1, 4'd1, 1'b0);
      for (int t = 0; t < DIR_ROWS; t++) begin
         if (dir_tab[t].typed) begin
            e.out_row   = '0;
            e.out_col   = '0;
            e.out_value = dir_tab[t].want;
            e.last      = 1'b1;
            e.sat       = dir_tab[t].want_sat;
            add_expected(e);
         end
         send_item(dir_tab[t].op, dir_tab[t].row, dir_tab[t].col, dir_tab[t].data,
                   pick_gap(), !dir_tab[t].typed);
      end

      // full size, sizes above range, empty result, zero inner size
      run_phase(4'd8, 4'd8, 4'd8, 1'b0);
      run_phase(4'd15, 4'd15, 4'd15, 1'b1);
      run_phase(4'd0, 4'd3, 4'd2, 1'b0);
      run_phase(4'd2, 4'd3, 4'd0, 1'b0);
      run_phase(4'd3, 4'd0, 4'd2, 1'b0);
      run_phase(4'd9, 4'd1, 4'd12, 1'b0);
      run_phase(4'd1, 4'd8, 4'd1, 1'b0);
      while (items_sent < ITEMS)
         run_phase(rand_dim(), rand_dim(), rand_dim(), $urandom_range(0, 7) == 0);

      if (start) start <= 1'b0;
      while (product_q.size() != 0) @(posedge clock);
      repeat (END_WAIT) @(posedge clock);

      $display("sent %0d transactions (%0d starts) over %0d register writes",
               items_sent, starts_sent, csr_writes);
      $display("checked %0d result elements, %0d mismatches", results_seen, mismatches);
      if (mismatches == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
